// ===== rtl/core/bsa_pkg.sv =====
// Shared types and constants for the bit set allocator.
`default_nettype none

package bsa_pkg;

    localparam int MAX_BITS_DEF  = 1024;
    localparam int WORD_BITS_DEF = 32;

    localparam int ACTIVE_W  = 11;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int OPCODE_W  = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TEST_SET   = 3'd0,
        OP_TEST_CLEAR = 3'd1,
        OP_ALLOCATE   = 3'd2,
        OP_FIND_SET   = 3'd3,
        OP_SET_PREFIX = 3'd4,
        OP_CLEAR_ALL  = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [IDX_W-1:0]    bit_index;
        logic [LEN_W-1:0]    prefix_length;
    } t_in_item;

    typedef struct packed {
        logic             was_set;
        logic             found;
        logic [IDX_W-1:0] found_index;
        logic             index_error;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/bit_set_allocator.sv =====
// Bit set allocator: test/set/clear, allocate lowest zero, find lowest one, prefix load.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we (no wait)           | i_cfg_wdata (active_bits)
//
// One item at a time; a sequencer walks the word memory one word per cycle.
// test_set/test_clear scan up to the word holding the bit; a range error or unused code
// goes straight to the result. allocate/find_first_set scan until a hit or the limit.
// set_prefix/clear_all sweep every word of the store, one word written per cycle.
// After reset a clearing pass over every word runs with o_in_ready low.
// A result still held in the output register stalls the next item in S_FINISH.
`default_nettype none

module bit_set_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_BITS  = MAX_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // item input
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in_item,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out_item,
    // active_bits register
    input  wire logic                i_cfg_we,
    input  wire logic [ACTIVE_W-1:0] i_cfg_wdata
);

    // Store geometry
    localparam int STORE_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
    localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int OFF_W       = $clog2(WORD_BITS);
    localparam int CNT_W       = $clog2(STORE_BITS + 1);
    // bit-count width: covers the store, active_bits and prefix_length
    localparam int W           = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    localparam logic [W-1:0]  MAX_LIM   = W'(MAX_BITS);
    localparam logic [W-1:0]  WORD_STEP = W'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_FINISH
    } t_state;

    // ones in every bit position j with base + j < lim
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [W-1:0] lim,
                                                     input logic [W-1:0] base);
        logic [W-1:0]         d;
        logic [WORD_BITS-1:0] m;
        d = (lim > base) ? (lim - base) : '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            m[j] = (W'(j) < d);
        end
        return m;
    endfunction

    // position of the lowest set bit (0 when none)
    function automatic logic [OFF_W-1:0] lowest(input logic [WORD_BITS-1:0] m);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (m[j]) begin
                pos = OFF_W'(j);
            end
        end
        return pos;
    endfunction

    // ---------------------------------------------------------------
    // Control and payload registers
    // ---------------------------------------------------------------
    t_state               r_state,    n_state;
    logic                 r_init,     n_init;       // reset clearing pass running
    logic [OPCODE_W-1:0]  r_op,       n_op;
    logic [IDX_W-1:0]     r_idx,      n_idx;
    logic [W-1:0]         r_lim,      n_lim;        // effective active_bits
    logic [W-1:0]         r_plen,     n_plen;       // clamped prefix length
    logic [AW-1:0]        r_word,     n_word;       // read / sweep address
    logic [W-1:0]         r_base,     n_base;       // first bit index of r_word
    logic                 r_rd_vld,   n_rd_vld;     // r_rdata holds a scanned word
    logic [AW-1:0]        r_rd_word;
    logic [W-1:0]         r_rd_base;
    t_out_item            r_res,      n_res;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_item, n_out_item;
    logic [ACTIVE_W-1:0]  r_active,   n_active;

    // Word memory
    logic [WORD_BITS-1:0] r_mem [STORE_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_word];
    end

    // ---------------------------------------------------------------
    // Scan unit: one stored word per cycle
    // ---------------------------------------------------------------
    logic [W-1:0]         lim_now;
    logic                 word_last;
    logic [W-1:0]         rd_end;
    logic [WORD_BITS-1:0] cand;
    logic                 hit_any;
    logic [OFF_W-1:0]     hit_pos;
    logic                 test_hit;
    logic [OFF_W-1:0]     test_off;
    logic                 accept;

    assign lim_now   = (W'(r_active) > MAX_LIM) ? MAX_LIM : W'(r_active);
    assign word_last = (r_word == LAST_WORD);
    assign rd_end    = r_rd_base + WORD_STEP;
    // find_first_set looks for ones, allocate for zeros
    assign cand      = ((r_op == OP_FIND_SET) ? r_rdata : ~r_rdata)
                       & low_mask(r_lim, r_rd_base);
    assign hit_any   = |cand;
    assign hit_pos   = lowest(cand);
    assign test_hit  = (W'(r_idx) < rd_end);
    assign test_off  = OFF_W'(W'(r_idx) - r_rd_base);

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_state     = r_state;
        n_init      = r_init;
        n_op        = r_op;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_plen      = r_plen;
        n_word      = r_word;
        n_base      = r_base;
        n_rd_vld    = r_rd_vld;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_active    = i_cfg_we ? i_cfg_wdata : r_active;
        mem_we      = 1'b0;
        mem_waddr   = r_rd_word;
        mem_wdata   = r_rdata;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_in_item.opcode;
                    n_idx    = i_in_item.bit_index;
                    n_lim    = lim_now;
                    n_word   = '0;
                    n_base   = '0;
                    n_rd_vld = 1'b0;
                    n_res    = '0;
                    n_plen   = '0;
                    unique case (t_opcode'(i_in_item.opcode)) inside
                        OP_TEST_SET, OP_TEST_CLEAR: begin
                            if (W'(i_in_item.bit_index) >= lim_now) begin
                                n_res.index_error = 1'b1;
                                n_state           = S_FINISH;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ALLOCATE, OP_FIND_SET: begin
                            n_state = S_SCAN;
                        end
                        OP_SET_PREFIX: begin
                            n_plen  = (W'(i_in_item.prefix_length) > lim_now)
                                      ? lim_now : W'(i_in_item.prefix_length);
                            n_state = S_SWEEP;
                        end
                        OP_CLEAR_ALL: begin
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue the next read while the previous word is evaluated
                n_rd_vld = 1'b1;
                if (!word_last) begin
                    n_word = r_word + AW'(1);
                    n_base = r_base + WORD_STEP;
                end
                if (r_rd_vld) begin
                    if (r_op == OP_TEST_SET || r_op == OP_TEST_CLEAR) begin
                        if (test_hit) begin
                            n_res.was_set       = r_rdata[test_off];
                            mem_we              = 1'b1;
                            mem_wdata[test_off] = (r_op == OP_TEST_SET);
                            n_state             = S_FINISH;
                        end
                    end else if (hit_any) begin
                        n_res.found       = 1'b1;
                        n_res.found_index = IDX_W'(r_rd_base + W'(hit_pos));
                        if (r_op == OP_ALLOCATE) begin
                            mem_we             = 1'b1;
                            mem_wdata[hit_pos] = 1'b1;
                        end
                        n_state = S_FINISH;
                    end else if (rd_end >= r_lim || r_rd_word == LAST_WORD) begin
                        n_state = S_FINISH;
                    end
                end
            end

            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_word;
                mem_wdata = low_mask(r_plen, r_base);
                if (word_last) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_word = r_word + AW'(1);
                    n_base = r_base + WORD_STEP;
                end
            end

            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_item  = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_word      <= '0;
            r_base      <= '0;
            r_plen      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= ACTIVE_RESET;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_word      <= n_word;
            r_base      <= n_base;
            r_plen      <= n_plen;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            r_active    <= n_active;
        end
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_res      <= n_res;
        r_out_item <= n_out_item;
        r_rd_word  <= r_word;
        r_rd_base  <= r_base;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("item accepted while another is in work");

    a_no_out_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !o_out_valid)
        else $error("result produced during clearing pass");

    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.found && o_out_item.index_error))
        else $error("found and index_error both set");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.found) |-> (o_out_item.found_index == '0))
        else $error("found_index nonzero without a find");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state == S_SCAN) |-> r_rd_vld)
        else $error("scan write-back without a scanned word");

endmodule

`default_nettype wire

// ===== tb/sv/bit_set_allocator_tb.sv =====
// Self-checking testbench for the bit set allocator: directed table, then random phases.
`default_nettype none

module bit_set_allocator_tb;
    import bsa_pkg::*;

    // codes the package leaves unnamed; the block must treat them as no-ops
    localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no item moving
    localparam int unsigned SETTLE_CYCLES  = 40;    // one full scan plus margin
    localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int unsigned PHASE_ITEMS    = 140;
    localparam int unsigned NUM_PHASES     = 8;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        t_in_item            req;
        bit                  typed;    // result written into the table
        t_out_item           result;
        logic [ACTIVE_W-1:0] cfg_value;
    } table_row_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [ACTIVE_W-1:0] i_cfg_wdata;

    // shadow of the block: bit store and active_bits register
    bit [MAX_BITS_DEF-1:0] store_shadow;
    bit [ACTIVE_W-1:0]     active_bits_shadow;

    t_out_item   pending_results[$];
    table_row_t  directed_rows[$];

    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned idle_pct      = 0;   // sender idle chance per cycle
    int unsigned stall_pct     = 0;   // receiver stall chance per cycle
    int unsigned hold_requests = 0;

    bit_set_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned active_limit();
        return (active_bits_shadow > MAX_BITS_DEF) ? MAX_BITS_DEF : active_bits_shadow;
    endfunction

    // Applies one request to the shadow store and returns the result it must give.
    function automatic t_out_item predict_result(t_in_item req);
        t_out_item   res;
        int unsigned lim;
        int unsigned plen;
        int unsigned hit;
        bit          want;
        res = '0;
        lim = active_limit();
        case (req.opcode) inside
            OP_TEST_SET, OP_TEST_CLEAR: begin
                if (req.bit_index >= lim) begin
                    res.index_error = 1'b1;
                end else begin
                    res.was_set = store_shadow[req.bit_index];
                    store_shadow[req.bit_index] = (req.opcode == OP_TEST_SET);
                end
            end
            OP_ALLOCATE, OP_FIND_SET: begin
                want = (req.opcode == OP_FIND_SET);
                hit  = lim;
                for (int i = 0; i < lim && hit == lim; i++) begin
                    if (store_shadow[i] == want) hit = i;
                end
                if (hit < lim) begin
                    res.found       = 1'b1;
                    res.found_index = hit[IDX_W-1:0];
                    if (req.opcode == OP_ALLOCATE) store_shadow[hit] = 1'b1;
                end
            end
            OP_SET_PREFIX: begin
                plen = (req.prefix_length > lim) ? lim : req.prefix_length;
                // bits beyond active_bits are cleared too
                store_shadow = '0;
                for (int i = 0; i < plen; i++) store_shadow[i] = 1'b1;
            end
            OP_CLEAR_ALL: begin
                store_shadow = '0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item make_req(logic [OPCODE_W-1:0] op, int unsigned idx,
                                          int unsigned len);
        t_in_item req;
        req.opcode        = op;
        req.bit_index     = idx[IDX_W-1:0];
        req.prefix_length = len[LEN_W-1:0];
        return req;
    endfunction

    function automatic void row_req(logic [OPCODE_W-1:0] op, int unsigned idx,
                                    int unsigned len);
        table_row_t row;
        row.kind      = ROW_REQ;
        row.req       = make_req(op, idx, len);
        row.typed     = 1'b0;
        row.result    = '0;
        row.cfg_value = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_checked(logic [OPCODE_W-1:0] op, int unsigned idx,
                                        int unsigned len, bit was, bit fnd,
                                        int unsigned fidx, bit err);
        table_row_t row;
        row.kind                  = ROW_REQ;
        row.req                   = make_req(op, idx, len);
        row.typed                 = 1'b1;
        row.result.was_set        = was;
        row.result.found          = fnd;
        row.result.found_index    = fidx[IDX_W-1:0];
        row.result.index_error    = err;
        row.cfg_value             = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_cfg(int unsigned value);
        table_row_t row;
        row.kind      = ROW_CFG;
        row.req       = '0;
        row.typed     = 1'b0;
        row.result    = '0;
        row.cfg_value = value[ACTIVE_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // Random request, weighted toward in-range indexes and a busy store.
    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned lim;
        int unsigned pick;
        lim  = active_limit();
        pick = $urandom_range(99, 0);
        if (pick < 24)      req.opcode = OP_TEST_SET;
        else if (pick < 44) req.opcode = OP_TEST_CLEAR;
        else if (pick < 70) req.opcode = OP_ALLOCATE;
        else if (pick < 82) req.opcode = OP_FIND_SET;
        else if (pick < 91) req.opcode = OP_SET_PREFIX;
        else if (pick < 97) req.opcode = OP_CLEAR_ALL;
        else                req.opcode = $urandom_range(1, 0) ? OP_SPARE_6 : OP_SPARE_7;
        if (lim > 0 && $urandom_range(9, 0) < 8) begin
            req.bit_index = IDX_W'($urandom_range(lim - 1, 0));
        end else begin
            req.bit_index = IDX_W'($urandom_range(1023, 0));
        end
        case ($urandom_range(3, 0))
            0:       req.prefix_length = LEN_W'($urandom_range(2047, 0));
            1:       req.prefix_length = LEN_W'(lim);
            default: req.prefix_length = LEN_W'($urandom_range(lim, 0));
        endcase
        return req;
    endfunction

    // Offers one item; returns at the edge where it is accepted.
    task automatic send_request(t_in_item req, bit typed, t_out_item given);
        bit        taken;
        t_out_item predicted;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do begin
            @(negedge i_clk);
            taken = (o_in_ready === 1'b1);
            if (taken) begin
                predicted = predict_result(req);
                pending_results.push_back(typed ? given : predicted);
            end
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stop offering and wait until the block has nothing left in flight.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_active_bits(logic [ACTIVE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_bits_shadow = value;
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    // Result checker and activity counter; sampled mid-cycle, away from the edge.
    initial begin
        t_out_item want_item;
        bit        moved;
        forever begin
            @(negedge i_clk);
            moved = 1'b0;
            if (i_rst_n === 1'b1) begin
                if (i_in_valid && o_in_ready === 1'b1) moved = 1'b1;
                if (o_out_valid === 1'b1 && i_out_ready) begin
                    moved = 1'b1;
                    if (pending_results.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result: %p", o_out_item);
                    end else begin
                        want_item = pending_results.pop_front();
                        if (o_out_item.was_set     !== want_item.was_set     ||
                            o_out_item.found       !== want_item.found       ||
                            o_out_item.found_index !== want_item.found_index ||
                            o_out_item.index_error !== want_item.index_error) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display({"result mismatch: expected was_set=%0d found=%0d ",
                                          "index=%0d err=%0d, got was_set=%0d found=%0d ",
                                          "index=%0d err=%0d"},
                                         want_item.was_set, want_item.found,
                                         want_item.found_index, want_item.index_error,
                                         o_out_item.was_set, o_out_item.found,
                                         o_out_item.found_index, o_out_item.index_error);
                        end
                    end
                end
                quiet_cycles = moved ? 0 : quiet_cycles + 1;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int unsigned active_plan [NUM_PHASES];
        active_plan        = '{1024, 40, 1, 300, 32, 2047, 64, 1000};
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_in_item          = '0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        store_shadow       = '0;
        active_bits_shadow = ACTIVE_RESET;

        // Directed table: reset state, word edges, clamping, spare codes,
        // range errors, a zero-width store and a limit above the store size.
        row_checked(OP_FIND_SET,      0,    0, 0, 0,    0, 0);   // empty store
        row_checked(OP_ALLOCATE,      0,    0, 0, 1,    0, 0);
        row_checked(OP_ALLOCATE,      0,    0, 0, 1,    1, 0);
        row_checked(OP_TEST_SET,   1023,    0, 0, 0,    0, 0);   // top bit
        row_checked(OP_TEST_SET,   1023,    0, 1, 0,    0, 0);
        row_checked(OP_TEST_CLEAR, 1023,    0, 1, 0,    0, 0);
        row_checked(OP_TEST_CLEAR, 1023,    0, 0, 0,    0, 0);
        row_checked(OP_FIND_SET,      0,    0, 0, 1,    0, 0);
        row_checked(OP_SET_PREFIX,    0, 1024, 0, 0,    0, 0);   // full store
        row_checked(OP_ALLOCATE,      0,    0, 0, 0,    0, 0);   // nothing free
        row_checked(OP_SET_PREFIX,    0, 2047, 0, 0,    0, 0);   // length clamped
        row_checked(OP_TEST_CLEAR,  512,    0, 1, 0,    0, 0);
        row_checked(OP_ALLOCATE,      0,    0, 0, 1,  512, 0);
        row_checked(OP_CLEAR_ALL,  1023, 2047, 0, 0,    0, 0);
        row_checked(OP_FIND_SET,      0,    0, 0, 0,    0, 0);   // nothing set
        row_req    (OP_SET_PREFIX,    0,   37);                  // crosses a word
        row_req    (OP_ALLOCATE,      0,    0);
        row_checked(OP_SPARE_6,    1023, 2047, 0, 0,    0, 0);
        row_checked(OP_SPARE_7,    1023, 2047, 0, 0,    0, 0);
        row_cfg(1);
        row_checked(OP_TEST_SET,      1,    0, 0, 0,    0, 1);   // just past the limit
        row_req    (OP_ALLOCATE,      0,    0);
        row_req    (OP_TEST_CLEAR,    0,    0);
        row_cfg(0);
        row_checked(OP_TEST_SET,      0,    0, 0, 0,    0, 1);   // no bit in use
        row_checked(OP_ALLOCATE,      0,    0, 0, 0,    0, 0);
        row_req    (OP_FIND_SET,      0,    0);
        row_cfg(2047);                                           // acts as the full store
        row_req    (OP_FIND_SET,      0,    0);                  // hidden bits visible again
        row_req    (OP_TEST_SET,   1023,    0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle_block();
                write_active_bits(directed_rows[r].cfg_value);
            end else begin
                send_request(directed_rows[r].req, directed_rows[r].typed,
                             directed_rows[r].result);
            end
        end

        // Random phases: idling pattern cycles through none / sender / receiver / both.
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle_block();
            write_active_bits(ACTIVE_W'(active_plan[p]));
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 58; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back-pressure burst: the sender keeps offering while output is held
                if (p == 0 && n == 10) hold_requests++;
                send_request(random_request(), 1'b0, '0);
            end
        end

        settle_block();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
